// ----- rtl/sequence_store_purge_matches_defines.svh -----
// ----------------------------------------------------------------------------
// sequence_store_purge_matches_defines
// Assertion macros shared by the sequence store RTL.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_STORE_PURGE_MATCHES_DEFINES_SVH
`define SEQUENCE_STORE_PURGE_MATCHES_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspm: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SSPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspm: next-cycle check failed");

`endif

// ----- rtl/sspm_pkg.sv -----
// ----------------------------------------------------------------------------
// sspm_pkg
// Shared types and constants of the sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package sspm_pkg;

   localparam int SSPM_DEPTH      = 16;
   localparam int SSPM_VALUE_W    = 32;
   localparam int SSPM_REQ_DATA_W = 40;
   localparam int SSPM_RSP_DATA_W = 72;
   localparam int SSPM_OCC_W      = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_PURGE      = 2'd2
   } opcode_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_PURGE = 1'b1
   } state_type;

   // Handshake between the control and the purge engine.
   typedef struct packed {
      logic busy;
      logic done;
   } purge_status_type;

endpackage

`default_nettype wire

// ----- rtl/sspm_ram.sv -----
// ----------------------------------------------------------------------------
// sspm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sspm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/sspm_purge.sv -----
// ----------------------------------------------------------------------------
// sspm_purge
// Purge engine: streams the live entries out of the RAM and writes the ones
// that do not match back towards the front, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sspm_purge
   import sspm_pkg::*;
#(
   parameter int DEPTH = SSPM_DEPTH,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [SSPM_VALUE_W-1:0] match_value,
   input  wire logic [AW-1:0]           first_slot,
   input  wire logic [CW-1:0]           count,
   input  wire logic [SSPM_VALUE_W-1:0] rd_data,
   output logic                         rd_en,
   output logic      [AW-1:0]           rd_addr,
   output logic                         wr_en,
   output logic      [AW-1:0]           wr_addr,
   output logic      [SSPM_VALUE_W-1:0] wr_data,
   output purge_status_type             status,
   output logic      [CW-1:0]           kept_count,
   output logic      [SSPM_VALUE_W-1:0] kept_front,
   output logic      [SSPM_VALUE_W-1:0] kept_back
);

   `include "sequence_store_purge_matches_defines.svh"

   localparam int SW = CW + 1;

   logic                    active_ff, active_in;
   logic                    pend_ff, pend_in;
   logic [CW-1:0]           issue_ff, issue_in;
   logic [CW-1:0]           keep_ff, keep_in;
   logic [SSPM_VALUE_W-1:0] value_ff, value_in;
   logic [SSPM_VALUE_W-1:0] front_ff, front_in;
   logic [SSPM_VALUE_W-1:0] back_ff, back_in;
   logic                    done;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] pos);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(pos);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      active_in = active_ff;
      pend_in   = 1'b0;
      issue_in  = issue_ff;
      keep_in   = keep_ff;
      value_in  = value_ff;
      front_in  = front_ff;
      back_in   = back_ff;
      rd_en     = 1'b0;
      rd_addr   = slot_of(first_slot, issue_ff);
      wr_en     = 1'b0;
      wr_addr   = slot_of(first_slot, keep_ff);
      wr_data   = rd_data;
      done      = 1'b0;
      if (start) begin
         active_in = 1'b1;
         issue_in  = '0;
         keep_in   = '0;
         value_in  = match_value;
      end else if (active_ff) begin
         // Issue the next read while the previous entry is checked.
         rd_en    = issue_ff != count;
         issue_in = rd_en ? issue_ff + 1'b1 : issue_ff;
         pend_in  = rd_en;
         if (pend_ff && rd_data != value_ff) begin
            wr_en   = 1'b1;
            keep_in = keep_ff + 1'b1;
            back_in = rd_data;
            if (keep_ff == '0) begin
               front_in = rd_data;
            end
         end
         if (!rd_en && !pend_ff) begin
            done      = 1'b1;
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      keep_ff  <= keep_in;
      value_ff <= value_in;
      front_ff <= front_in;
      back_ff  <= back_in;
   end

   assign status.busy = active_ff;
   assign status.done = done;
   assign kept_count  = keep_ff;
   assign kept_front  = front_ff;
   assign kept_back   = back_ff;

   // Compaction never writes at or beyond the entry being fetched.
   `SSPM_ASSERT_NOW(a_write_behind_read, clock, reset, wr_en, keep_ff < issue_ff)

endmodule

`default_nettype wire

// ----- rtl/sequence_store_purge_matches.sv -----
// ----------------------------------------------------------------------------
// sequence_store_purge_matches
// Bounded double-ended store of signed 32-bit values with delete-all-matches.
// ----------------------------------------------------------------------------
// The store holds up to DEPTH entries in a circular buffer kept in one RAM
// with a registered read port. Each request transfer carries an opcode and a
// value: push at the front, push at the back, or purge every entry equal to
// the value (survivors keep their order and are packed towards the front).
// Every request yields exactly one response transfer with the front and back
// values (zero when empty), the occupancy, an empty flag and a flag that a
// push was refused because the store was full. For pushes and the unused
// opcode the response is registered at the edge that takes the request. A
// purge hands the sweep to the purge engine, which fetches one entry per
// cycle through the single RAM read port and writes survivors back through
// the write port. One request is in flight at a time; a new request is
// taken in the cycle its predecessor's response is taken. The RAM needs no
// clearing after reset: only live entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_store_purge_matches
   import sspm_pkg::*;
#(
   parameter int DEPTH = SSPM_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // req_tdata: opcode[1:0], value[33:2], zero[39:34]
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [SSPM_REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: front_value[31:0], back_value[63:32], occupancy[68:64],
   //            is_empty[69], push_dropped[70], zero[71]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [SSPM_RSP_DATA_W-1:0] rsp_tdata
);

   `include "sequence_store_purge_matches_defines.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   // Control state and the cached ends of the store.
   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           first_ff, first_in;
   logic [SSPM_VALUE_W-1:0] front_ff, front_in;
   logic [SSPM_VALUE_W-1:0] back_ff, back_in;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SSPM_RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_load;
   logic                       dropped;

   // Request fields.
   logic [1:0]              req_opcode;
   logic [SSPM_VALUE_W-1:0] req_value;
   logic                    req_accept;
   logic                    full;

   // RAM ports.
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [SSPM_VALUE_W-1:0] ram_wr_data;
   logic [SSPM_VALUE_W-1:0] ram_rd_data;
   logic                    push_wr_en;
   logic [AW-1:0]           push_wr_addr;

   // Purge engine.
   logic                    purge_start;
   logic                    purge_rd_en;
   logic [AW-1:0]           purge_rd_addr;
   logic                    purge_wr_en;
   logic [AW-1:0]           purge_wr_addr;
   logic [SSPM_VALUE_W-1:0] purge_wr_data;
   purge_status_type        purge_status;
   logic [CW-1:0]           kept_count;
   logic [SSPM_VALUE_W-1:0] kept_front;
   logic [SSPM_VALUE_W-1:0] kept_back;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] pos);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(pos);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign req_opcode = req_tdata[1:0];
   assign req_value  = req_tdata[33:2];

   // Take a request only when idle and the response slot is free or draining.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign full       = count_ff == CW'(DEPTH);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      push_wr_en   = 1'b0;
      push_wr_addr = first_ff;
      purge_start  = 1'b0;
      rsp_load     = 1'b0;
      dropped      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_load = 1'b1;
               case (req_opcode)
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        dropped = 1'b1;
                     end else begin
                        // Step the front slot back, wrapping at zero.
                        first_in     = (first_ff == '0) ? AW'(DEPTH - 1)
                                                        : first_ff - 1'b1;
                        push_wr_en   = 1'b1;
                        push_wr_addr = first_in;
                        count_in     = count_ff + 1'b1;
                        front_in     = req_value;
                        if (count_ff == '0) begin
                           back_in = req_value;
                        end
                     end
                  end
                  OP_PUSH_BACK: begin
                     if (full) begin
                        dropped = 1'b1;
                     end else begin
                        push_wr_en   = 1'b1;
                        push_wr_addr = slot_of(first_ff, count_ff);
                        count_in     = count_ff + 1'b1;
                        back_in      = req_value;
                        if (count_ff == '0) begin
                           front_in = req_value;
                        end
                     end
                  end
                  OP_PURGE: begin
                     // Hold the response until the engine has swept the store.
                     rsp_load    = 1'b0;
                     purge_start = 1'b1;
                     state_in    = ST_PURGE;
                  end
                  default: begin
                     // Unused code: report the current status unchanged.
                  end
               endcase
            end
         end
         ST_PURGE: begin
            if (purge_status.done) begin
               count_in = kept_count;
               front_in = kept_front;
               back_in  = kept_back;
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Build the response from the post-step state.
   always_comb begin
      rsp_data_in         = '0;
      rsp_data_in[63:0]   = (count_in == '0) ? 64'd0 : {back_in, front_in};
      rsp_data_in[68:64]  = SSPM_OCC_W'(count_in);
      rsp_data_in[69]     = count_in == '0;
      rsp_data_in[70]     = dropped;
      rsp_valid_in        = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_ff <= front_in;
      back_ff  <= back_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Pushes and the purge engine never write in the same cycle.
   assign ram_wr_en   = push_wr_en || purge_wr_en;
   assign ram_wr_addr = purge_wr_en ? purge_wr_addr : push_wr_addr;
   assign ram_wr_data = purge_wr_en ? purge_wr_data : req_value;

   sspm_ram #(
      .WIDTH (SSPM_VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (purge_rd_en),
      .rd_addr (purge_rd_addr),
      .rd_data (ram_rd_data)
   );

   sspm_purge #(
      .DEPTH (DEPTH)
   ) u_purge (
      .clock       (clock),
      .reset       (reset),
      .start       (purge_start),
      .match_value (req_value),
      .first_slot  (first_ff),
      .count       (count_ff),
      .rd_data     (ram_rd_data),
      .rd_en       (purge_rd_en),
      .rd_addr     (purge_rd_addr),
      .wr_en       (purge_wr_en),
      .wr_addr     (purge_wr_addr),
      .wr_data     (purge_wr_data),
      .status      (purge_status),
      .kept_count  (kept_count),
      .kept_front  (kept_front),
      .kept_back   (kept_back)
   );

   // A refused push leaves the occupancy untouched.
   `SSPM_ASSERT_NEXT(a_drop_holds_count, clock, reset, dropped, $stable(count_ff))
   // No new request while the engine is sweeping.
   `SSPM_ASSERT_NOW(a_no_accept_in_purge, clock, reset, purge_status.busy, !req_tready)
   // A new response never overwrites one that is still waiting.
   `SSPM_ASSERT_NOW(a_rsp_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_tready)

endmodule

`default_nettype wire

// ----- tb/sequence_store_purge_matches_checker.sv -----
// ----------------------------------------------------------------------------
// sequence_store_purge_matches_checker
// Watches both streams of the sequence store, keeps its own copy of the
// circular store and compares every response transfer with the status that
// copy gives for the oldest outstanding request.
// ----------------------------------------------------------------------------
module sequence_store_purge_matches_checker
   import sspm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // req_tdata: opcode[1:0], value[33:2], zero[39:34]
   input  logic [SSPM_REQ_DATA_W-1:0] req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // rsp_tdata: front_value[31:0], back_value[63:32], occupancy[68:64],
   //            is_empty[69], push_dropped[70], zero[71]
   input  logic [SSPM_RSP_DATA_W-1:0] rsp_tdata,
   output int                         mismatch_count,
   output int                         pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SSPM_VALUE_W-1:0] front_value;
      logic [SSPM_VALUE_W-1:0] back_value;
      logic [SSPM_OCC_W-1:0]   occupancy;
      logic                    is_empty;
      logic                    push_dropped;
   } store_status_type;

   logic [SSPM_VALUE_W-1:0] slot_value [SSPM_DEPTH];
   int                      live_count = 0;
   int                      head_slot = 0;
   int                      failures = 0;
   store_status_type        expected_status_q [$];

   // Apply one request to the local copy of the store and return the status
   // the block must report for it.
   function automatic store_status_type apply_request(input logic [1:0] op,
                                                      input logic [SSPM_VALUE_W-1:0] value);
      store_status_type        status;
      logic [SSPM_VALUE_W-1:0] survivors [SSPM_DEPTH];
      int                      kept;
      status = '0;
      kept = 0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
         if (live_count >= SSPM_DEPTH) begin
            status.push_dropped = 1'b1;
         end else if (op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + SSPM_DEPTH - 1) % SSPM_DEPTH;
            slot_value[head_slot] = value;
            live_count++;
         end else begin
            slot_value[(head_slot + live_count) % SSPM_DEPTH] = value;
            live_count++;
         end
      end else if (op == OP_PURGE) begin
         // gather survivors in order, then pack them from the head slot on
         for (int i = 0; i < live_count; i++) begin
            if (slot_value[(head_slot + i) % SSPM_DEPTH] != value) begin
               survivors[kept] = slot_value[(head_slot + i) % SSPM_DEPTH];
               kept++;
            end
         end
         for (int i = 0; i < kept; i++) begin
            slot_value[(head_slot + i) % SSPM_DEPTH] = survivors[i];
         end
         live_count = kept;
      end
      // the unused opcode leaves the store alone and just reports it
      status.occupancy = SSPM_OCC_W'(live_count);
      status.is_empty  = (live_count == 0);
      if (live_count != 0) begin
         status.front_value = slot_value[head_slot];
         status.back_value  = slot_value[(head_slot + live_count - 1) % SSPM_DEPTH];
      end
      return status;
   endfunction

   always @(posedge clock) begin
      store_status_type seen;
      store_status_type want;
      store_status_type next_status;
      if (reset) begin
         live_count = 0;
         head_slot = 0;
         expected_status_q.delete();
      end else begin
         // the response of an earlier request may leave on the same edge as
         // the next request arrives: check it first
         if (rsp_tvalid && rsp_tready) begin
            seen.front_value  = rsp_tdata[31:0];
            seen.back_value   = rsp_tdata[63:32];
            seen.occupancy    = rsp_tdata[68:64];
            seen.is_empty     = rsp_tdata[69];
            seen.push_dropped = rsp_tdata[70];
            if (expected_status_q.size() == 0) begin
               if (failures < REPORT_LIMIT) begin
                  $display("sspm check: response at %0t with no request outstanding", $time);
               end
               failures++;
            end else begin
               want = expected_status_q.pop_front();
               if (seen !== want) begin
                  if (failures < REPORT_LIMIT) begin
                     $display({"sspm check: mismatch at %0t: expected front %h back %h ",
                               "occupancy %0d empty %b dropped %b, got front %h back %h ",
                               "occupancy %0d empty %b dropped %b"}, $time,
                              want.front_value, want.back_value, want.occupancy,
                              want.is_empty, want.push_dropped,
                              seen.front_value, seen.back_value, seen.occupancy,
                              seen.is_empty, seen.push_dropped);
                  end
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            next_status = apply_request(req_tdata[1:0], req_tdata[33:2]);
            expected_status_q.insert(expected_status_q.size(), next_status);
         end
      end
      mismatch_count  <= failures;
      pending_results <= expected_status_q.size();
   end

endmodule

// ----- tb/sequence_store_purge_matches_tb.sv -----
// ----------------------------------------------------------------------------
// sequence_store_purge_matches_tb
// Regression for the sequence store: a directed opening over the value
// extremes, the full and empty store and every opcode, then random runs of
// pushes, purges and the unused opcode drawn from small value pools, with
// random idling on both streams. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sequence_store_purge_matches_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sspm_pkg::*;

   localparam int         RANDOM_ITEMS = 1900;
   localparam int         BLOCK_ITEMS  = 100;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   // drain margin, sized to cover a purge of a full store
   localparam int         DRAIN_CYCLES = 2 * SSPM_DEPTH + 8;
   // the opcode the block leaves unused
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   // req_tdata: opcode[1:0], value[33:2], zero[39:34]
   logic [SSPM_REQ_DATA_W-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   // rsp_tdata: front_value[31:0], back_value[63:32], occupancy[68:64],
   //            is_empty[69], push_dropped[70], zero[71]
   logic [SSPM_RSP_DATA_W-1:0] rsp_tdata;

   int   mismatch_count;
   int   pending_results;
   int   cycle_count = 0;
   int   stall_left = 0;
   logic sender_idles = 1'b0;
   logic receiver_stalls = 1'b0;

   always #5 clock = ~clock;

   sequence_store_purge_matches dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sequence_store_purge_matches_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Hold a request on the stream until it is taken, then idle the sender
   // for a random gap if idling is on. Keep tvalid high across back-to-back
   // transfers rather than dropping and raising it in the same step.
   task automatic send_request(input logic [1:0] op, input logic [SSPM_VALUE_W-1:0] value);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(SSPM_REQ_DATA_W - SSPM_VALUE_W - 2){1'b0}}, value, op};
      do @(posedge clock); while (!req_tready);
      gap = sender_idles ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: stall at random while stalls are enabled, otherwise
   // accept every transfer.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 99) < 25) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sequence_store_purge_matches regression: fail");
      $finish;
   end

   initial begin
      logic [SSPM_VALUE_W-1:0] value_pool [4];
      logic [SSPM_VALUE_W-1:0] value;
      logic [1:0]              op;
      int                      push_pct;
      int                      counted;
      int                      roll;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sender_idles = 1'b1;
      receiver_stalls <= 1'b1;

      // Directed opening: purge and the unused opcode on an empty store,
      // the two value extremes at either end, a fill that wraps the head
      // slot round to the top, refused pushes on a full store, a purge
      // with no match, and purges that strip the store back to empty.
      send_request(OP_PURGE, 32'h0000_0000);
      send_request(OP_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_PUSH_BACK, 32'h7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      for (int i = 0; i < SSPM_DEPTH - 2; i++) begin
         send_request((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'hFFFF_FFFF);
      end
      send_request(OP_PUSH_FRONT, 32'h1234_5678);
      send_request(OP_PUSH_BACK, 32'h8765_4321);
      send_request(OP_UNUSED, 32'h0000_0000);
      send_request(OP_PURGE, 32'h0000_0000);
      send_request(OP_PURGE, 32'hFFFF_FFFF);
      send_request(OP_PURGE, 32'h8000_0000);
      send_request(OP_PURGE, 32'h7FFF_FFFF);

      // Random part in blocks: each block draws a fill bias, a small pool
      // of values so that purges find matches, and its own idling pattern.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0:       push_pct = 35;
            1:       push_pct = 55;
            default: push_pct = 80;
         endcase
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
               0:       value_pool[k] = 32'h8000_0000;
               1:       value_pool[k] = 32'h7FFF_FFFF;
               2:       value_pool[k] = 32'h0000_0000;
               3:       value_pool[k] = 32'hFFFF_FFFF;
               default: value_pool[k] = $urandom;
            endcase
         end
         sender_idles = ($urandom_range(0, 3) != 0);
         receiver_stalls <= ($urandom_range(0, 3) != 0);
         repeat (BLOCK_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               op = OP_UNUSED;
            end else if (roll < 2 + push_pct) begin
               op = ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
               op = OP_PURGE;
            end
            value = ($urandom_range(0, 99) < 80) ? value_pool[$urandom_range(0, 3)] : $urandom;
            send_request(op, value);
            counted++;
         end
      end
      req_tvalid <= 1'b0;

      // Drain: the pending count is registered, so it trails each transfer; step
      // to the next edge before polling it, then let any stray response show up.
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("sequence_store_purge_matches regression: pass");
      end else begin
         $display("sequence_store_purge_matches regression: fail");
      end
      $finish;
   end

endmodule
